// File: hw/rtl/hrsl_pkg.sv
// Shared types and codes for the hash ring successor lookup block.
package hrsl_pkg;

  localparam int POS_W     = 32;
  localparam int NODE_IN_W = 8;
  localparam int MODE_W    = 2;
  localparam int STATUS_W  = 2;
  localparam int CNT_OUT_W = 11;

  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_CMP,
    ST_FIN,
    ST_OWN,
    ST_SHIFT,
    ST_INS,
    ST_EMIT
  } hrsl_state_t;

endpackage

// File: hw/rtl/hrsl_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module hrsl_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/hash_ring_successor_lookup.sv
// Top level of the hash ring successor lookup: sorted point table and its sequencer.
//
// One input beat carries an operation on in_tuser (clear, insert, lookup) and its
// operands on in_tdata. Every input beat yields exactly one output beat with the
// chosen node, a status code and the number of points held afterwards.
// The ring lives in one RAM of MAX_POINTS words, each a position and its owner,
// kept in ascending order of position. A lookup is a binary search that issues
// one RAM read per cycle, then one more read for the owner of the point found.
// An insert runs the same search and then moves every larger entry up by one
// place, one entry per cycle through the RAM read and write ports. Clear and
// failed operations go straight to the output without a search. One item is in
// work at a time; the next is taken as soon as the result sits in the output
// register, even while it waits. A stalled receiver holds the output beat; a
// finished result then waits until the output register is free. Reset empties
// the ring at once; the RAM contents are not cleared, since no entry at or above
// the point count is ever read.
module hash_ring_successor_lookup #(
  parameter int MAX_POINTS = 1024,
  parameter int NODE_BITS  = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [31:0] point_position, [39:32] point_node, [71:40] key_hash
  input  logic [71:0] in_tdata,
  // [1:0] mode
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] node_index, [9:8] status, [20:10] point_count
  output logic [23:0] out_tdata
);

  import hrsl_pkg::*;

  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int WORD_W = POS_W + NODE_BITS;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_POINTS);

  hrsl_state_t state_r, state_nxt;

  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     lo_r, lo_nxt;
  logic [CNT_W-1:0]     hi_r, hi_nxt;
  logic [CNT_W-1:0]     mid_r, mid_nxt;
  logic [IDX_W-1:0]     at_r, at_nxt;
  logic [IDX_W-1:0]     ptr_r, ptr_nxt;
  logic                 ins_r, ins_nxt;
  logic [POS_W-1:0]     key_r, key_nxt;
  logic [NODE_BITS-1:0] node_r, node_nxt;
  logic [NODE_BITS-1:0] res_node_r, res_node_nxt;
  logic [STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [23:0]          out_data_r, out_data_nxt;

  logic                 ram_wr_en, ram_rd_en;
  logic [IDX_W-1:0]     ram_wr_addr, ram_rd_addr;
  logic [WORD_W-1:0]    ram_wr_data, ram_rd_data;

  logic [MODE_W-1:0]    in_mode;
  logic [POS_W-1:0]     in_pos, in_hash;
  logic [NODE_IN_W-1:0] in_node;
  logic                 in_fire, out_free;
  logic [POS_W-1:0]     rd_pos;
  logic                 go_right;
  logic [CNT_W-1:0]     lo_s, hi_s, mid_s;
  logic [NODE_BITS+NODE_IN_W-1:0] node_in_ext;
  logic [NODE_BITS+NODE_IN_W-1:0] node_out_ext;
  logic [CNT_W+CNT_OUT_W-1:0]     cnt_ext;

  assign in_mode = in_tuser[MODE_W-1:0];
  assign in_pos  = in_tdata[31:0];
  assign in_node = in_tdata[39:32];
  assign in_hash = in_tdata[71:40];

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign node_in_ext  = {{NODE_BITS{1'b0}}, in_node};
  assign node_out_ext = {{NODE_IN_W{1'b0}}, res_node_r};
  assign cnt_ext      = {{CNT_OUT_W{1'b0}}, cnt_r};

  // Search step: inserts go past equal positions, lookups stop at the first equal one.
  assign rd_pos   = ram_rd_data[POS_W-1:0];
  assign go_right = ins_r ? (rd_pos <= key_r) : (rd_pos < key_r);
  assign lo_s     = (state_r == ST_CMP) ? (go_right ? mid_r + CNT_W'(1) : lo_r) : lo_r;
  assign hi_s     = (state_r == ST_CMP) ? (go_right ? hi_r : mid_r) : hi_r;
  assign mid_s    = lo_s + ((hi_s - lo_s) >> 1);

  hrsl_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    at_r         <= at_nxt;
    ptr_r        <= ptr_nxt;
    ins_r        <= ins_nxt;
    key_r        <= key_nxt;
    node_r       <= node_nxt;
    res_node_r   <= res_node_nxt;
    res_status_r <= res_status_nxt;
    out_data_r   <= out_data_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    at_nxt         = at_r;
    ptr_nxt        = ptr_r;
    ins_nxt        = ins_r;
    key_nxt        = key_r;
    node_nxt       = node_r;
    res_node_nxt   = res_node_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = ptr_r;
    ram_wr_data    = ram_rd_data;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = mid_s[IDX_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          ins_nxt        = (in_mode == MODE_INSERT);
          key_nxt        = (in_mode == MODE_INSERT) ? in_pos : in_hash;
          node_nxt       = node_in_ext[NODE_BITS-1:0];
          res_node_nxt   = '0;
          res_status_nxt = STATUS_OK;
          lo_nxt         = '0;
          hi_nxt         = cnt_r;
          state_nxt      = ST_EMIT;
          case (in_mode)
            MODE_CLEAR: begin
              cnt_nxt = '0;
            end
            MODE_INSERT: begin
              if (cnt_r == MAX_CNT) begin
                res_status_nxt = STATUS_FULL;
              end else begin
                state_nxt = ST_SRCH;
              end
            end
            MODE_LOOKUP: begin
              if (cnt_r == '0) begin
                res_status_nxt = STATUS_EMPTY;
              end else begin
                state_nxt = ST_SRCH;
              end
            end
            default: begin
              state_nxt = ST_EMIT;
            end
          endcase
        end
      end
      ST_SRCH, ST_CMP: begin
        lo_nxt = lo_s;
        hi_nxt = hi_s;
        if (lo_s < hi_s) begin
          ram_rd_en = 1'b1;
          mid_nxt   = mid_s;
          state_nxt = ST_CMP;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (ins_r) begin
          at_nxt  = lo_r[IDX_W-1:0];
          ptr_nxt = cnt_r[IDX_W-1:0];
          if (cnt_r > lo_r) begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = cnt_r[IDX_W-1:0] - IDX_W'(1);
            state_nxt   = ST_SHIFT;
          end else begin
            state_nxt = ST_INS;
          end
        end else begin
          // Past the last point the ring wraps to its first entry.
          ram_rd_en   = 1'b1;
          ram_rd_addr = (lo_r >= cnt_r) ? '0 : lo_r[IDX_W-1:0];
          state_nxt   = ST_OWN;
        end
      end
      ST_OWN: begin
        res_node_nxt = ram_rd_data[POS_W +: NODE_BITS];
        state_nxt    = ST_EMIT;
      end
      ST_SHIFT: begin
        // Write the entry read last cycle one place up while reading the next one down.
        ram_wr_en   = 1'b1;
        ram_wr_addr = ptr_r;
        ram_wr_data = ram_rd_data;
        ptr_nxt     = ptr_r - IDX_W'(1);
        if ((ptr_r - IDX_W'(1)) > at_r) begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = ptr_r - IDX_W'(2);
        end else begin
          state_nxt = ST_INS;
        end
      end
      ST_INS: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = at_r;
        ram_wr_data = {node_r, key_r};
        cnt_nxt     = cnt_r + CNT_W'(1);
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {3'b000, cnt_ext[CNT_OUT_W-1:0], res_status_r,
                           node_out_ext[NODE_IN_W-1:0]};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: hw/rtl/hrsl_chk.sv
// Port-level checker for the hash ring successor lookup, bound to the top level.
module hrsl_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  import hrsl_pkg::*;

  logic [7:0]          chk_node;
  logic [STATUS_W-1:0] chk_status;
  logic [10:0]         chk_count;

  assign chk_node   = out_tdata[7:0];
  assign chk_status = out_tdata[9:8];
  assign chk_count  = out_tdata[20:10];

  // A result beat that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output beat shown right after reset");

  // An empty ring reports no points and no owner.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && chk_status == STATUS_EMPTY |-> chk_node == 8'd0 && chk_count == 11'd0)
    else $error("empty-ring result carries a node or a count");

  a_fail_node: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && chk_status == STATUS_FULL |-> chk_node == 8'd0)
    else $error("full-table result carries a node");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> chk_status == STATUS_OK || chk_status == STATUS_EMPTY ||
                   chk_status == STATUS_FULL)
    else $error("unknown status code");

endmodule

bind hash_ring_successor_lookup hrsl_chk u_hrsl_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: tb/hash_ring_successor_lookup_test.sv
// Self-checking testbench for the hash ring successor lookup block.
module hash_ring_successor_lookup_test;
  import hrsl_pkg::*;

  localparam int MAX_POINTS = 1024;
  localparam int NODE_BITS  = 8;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 5000;
  localparam int DEEP_POINTS = 300;

  // Packed with the last member in the lowest bits, matching out_tdata.
  typedef struct packed {
    logic [CNT_OUT_W-1:0] point_count;
    logic [STATUS_W-1:0]  status;
    logic [NODE_IN_W-1:0] node_index;
  } ring_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;

  // Our own copy of the sorted ring.
  logic [POS_W-1:0]     ring_pos   [MAX_POINTS];
  logic [NODE_IN_W-1:0] ring_owner [MAX_POINTS];
  int unsigned          ring_size = 0;

  ring_result_t pending_results[$];
  int unsigned  mismatches = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  hold_left = 0;
  bit           bursty = 1'b1;
  bit           calm = 1'b0;

  hash_ring_successor_lookup #(
    .MAX_POINTS(MAX_POINTS),
    .NODE_BITS (NODE_BITS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #5 clk = ~clk;

  // Applies one operation to the ring copy and returns the beat it should produce.
  function automatic ring_result_t apply_ring_op(logic [MODE_W-1:0] mode,
                                                 logic [POS_W-1:0] pos,
                                                 logic [NODE_IN_W-1:0] node,
                                                 logic [POS_W-1:0] hash);
    ring_result_t r;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    r = '0;
    case (mode)
      MODE_CLEAR: begin
        ring_size = 0;
      end
      MODE_INSERT: begin
        if (ring_size >= MAX_POINTS) begin
          r.status = STATUS_FULL;
        end else begin
          // A new point goes after every point already at its position.
          lo = 0;
          hi = ring_size;
          while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (ring_pos[mid] <= pos) lo = mid + 1;
            else hi = mid;
          end
          for (int i = ring_size; i > lo; i--) begin
            ring_pos[i]   = ring_pos[i-1];
            ring_owner[i] = ring_owner[i-1];
          end
          ring_pos[lo]   = pos;
          ring_owner[lo] = node;
          ring_size++;
        end
      end
      MODE_LOOKUP: begin
        if (ring_size == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          lo = 0;
          hi = ring_size;
          while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (ring_pos[mid] < hash) lo = mid + 1;
            else hi = mid;
          end
          if (lo >= ring_size) lo = 0;
          r.node_index = ring_owner[lo];
        end
      end
      default: ;
    endcase
    r.point_count = CNT_OUT_W'(ring_size);
    return r;
  endfunction

  // Offers one input beat, waits for it to be taken, then records its expected result.
  task automatic push_ring_op(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
                              logic [31:0] node_word, logic [POS_W-1:0] hash);
    logic [NODE_IN_W-1:0] node;
    node = node_word[NODE_IN_W-1:0];
    if (bursty && !calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {hash, node, pos};
    in_tuser  <= mode;
    do @(posedge clk); while (!in_tready);
    pending_results = {pending_results, apply_ring_op(mode, pos, node, hash)};
  endtask

  task automatic test_edge_cases();
    push_ring_op(MODE_LOOKUP, $urandom, $urandom, 32'h0000_0000);
    push_ring_op(MODE_LOOKUP, $urandom, $urandom, 32'hFFFF_FFFF);
    push_ring_op(MODE_UNUSED, $urandom, $urandom, $urandom);
    push_ring_op(MODE_CLEAR, $urandom, $urandom, $urandom);
    push_ring_op(MODE_INSERT, 32'hFFFF_FFFF, 32'h0000_00FF, $urandom);
    push_ring_op(MODE_LOOKUP, $urandom, $urandom, 32'h0000_0000);
    push_ring_op(MODE_LOOKUP, $urandom, $urandom, 32'hFFFF_FFFF);
    push_ring_op(MODE_INSERT, 32'h0000_0000, 32'h0000_0000, $urandom);
    push_ring_op(MODE_LOOKUP, $urandom, $urandom, 32'h0000_0000);
    push_ring_op(MODE_LOOKUP, $urandom, $urandom, 32'h0000_0001);
    // Two points at one position: the first inserted must answer.
    push_ring_op(MODE_INSERT, 32'h8000_0000, 32'h0000_000A, $urandom);
    push_ring_op(MODE_INSERT, 32'h8000_0000, 32'h0000_0014, $urandom);
    push_ring_op(MODE_LOOKUP, $urandom, $urandom, 32'h8000_0000);
    push_ring_op(MODE_LOOKUP, $urandom, $urandom, 32'h7FFF_FFFF);
    push_ring_op(MODE_LOOKUP, $urandom, $urandom, 32'h8000_0001);
    push_ring_op(MODE_UNUSED, $urandom, $urandom, $urandom);
    push_ring_op(MODE_CLEAR, $urandom, $urandom, $urandom);
    push_ring_op(MODE_LOOKUP, $urandom, $urandom, $urandom);
    // A hash past the only point wraps around to entry zero.
    push_ring_op(MODE_INSERT, 32'd100, 32'h0000_005A, $urandom);
    push_ring_op(MODE_LOOKUP, $urandom, $urandom, 32'd200);
    push_ring_op(MODE_LOOKUP, $urandom, $urandom, 32'd100);
    push_ring_op(MODE_CLEAR, $urandom, $urandom, $urandom);
  endtask

  task automatic test_deep_ring();
    // Descending positions make every insert move the whole ring up by one place.
    for (int i = 0; i < DEEP_POINTS; i++) begin
      push_ring_op(MODE_INSERT,
                   (POS_W'(DEEP_POINTS - i) << 20) | ($urandom & 32'h000F_FFFF),
                   $urandom, $urandom);
    end
    push_ring_op(MODE_INSERT, 32'h0000_0000, $urandom, $urandom);
    push_ring_op(MODE_INSERT, 32'hFFFF_FFFF, $urandom, $urandom);
    push_ring_op(MODE_INSERT, $urandom, $urandom, $urandom);
    push_ring_op(MODE_LOOKUP, $urandom, $urandom, 32'h0000_0000);
    push_ring_op(MODE_LOOKUP, $urandom, $urandom, 32'hFFFF_FFFF);
    push_ring_op(MODE_LOOKUP, $urandom, $urandom, ring_pos[$urandom_range(0, ring_size-1)]);
    for (int i = 0; i < 4; i++) push_ring_op(MODE_LOOKUP, $urandom, $urandom, $urandom);
    push_ring_op(MODE_CLEAR, $urandom, $urandom, $urandom);
  endtask

  task automatic test_random_traffic(int unsigned items);
    int unsigned       clear_odds;
    int unsigned       pick;
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  hash;
    logic [POS_W-1:0]  anchor;
    clear_odds = 50;
    for (int n = 0; n < items; n++) begin
      // Each stretch of a hundred items gets its own ring depth and idling.
      if (n % 100 == 0) begin
        clear_odds = $urandom_range(8, 300);
        bursty = ($urandom_range(0, 3) != 0);
      end
      pick = $urandom_range(0, 99);
      pos  = $urandom;
      hash = $urandom;
      anchor = (ring_size > 0) ? ring_pos[$urandom_range(0, ring_size - 1)] : $urandom;
      if (pick < 2) begin
        mode = MODE_UNUSED;
      end else if ($urandom_range(1, clear_odds) == 1) begin
        mode = MODE_CLEAR;
      end else if (pick < 50) begin
        mode = MODE_INSERT;
        if ($urandom_range(0, 3) == 0) pos = anchor + $urandom_range(0, 2) - 1;
      end else begin
        mode = MODE_LOOKUP;
        case ($urandom_range(0, 5))
          0: hash = anchor;
          1: hash = anchor + 1;
          2: hash = anchor - 1;
          3: hash = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
          default: ;
        endcase
      end
      push_ring_op(mode, pos, $urandom, hash);
    end
  endtask

  always @(posedge clk) begin
    if (calm || !bursty) begin
      out_tready <= 1'b1;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      hold_left  <= $urandom_range(0, 3);
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    ring_result_t want;
    ring_result_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[20:0];
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with no item outstanding, actual %h", $time, got);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (got.node_index !== want.node_index) begin
          $display("%0t: node_index expected %0d actual %0d", $time,
                   want.node_index, got.node_index);
          mismatches++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          mismatches++;
        end
        if (got.point_count !== want.point_count) begin
          $display("%0t: point_count expected %0d actual %0d", $time,
                   want.point_count, got.point_count);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_edge_cases();
    test_deep_ring();
    test_random_traffic(500);
    // The last stretch runs with both sides always ready.
    calm = 1'b1;
    test_random_traffic(60);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
